/* rtl/core/bdr_pkg.sv */
package bdr_pkg;

  localparam int ADDR_BITS   = 24;
  localparam int MAX_SECTORS = 32;
  localparam int SEC_W       = $clog2(MAX_SECTORS + 1);
  localparam int UPC_W       = 5;
  localparam int TDATA_W     = 80;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SEC_W-1:0]     sec_t;
  typedef logic [UPC_W-1:0]     upc_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_FRAG,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    ACT_REPLY  = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_COMMIT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CHAR,
    EM_HEX,
    EM_ERASE,
    EM_DATA,
    EM_COMMIT
  } emit_t;

  typedef enum logic [1:0] {
    L_NO,
    L_YES,
    L_FRAG_NZ,
    L_NO_COMMIT
  } last_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_LEN_SHIFT,
    OP_CALC1,
    OP_CALC2,
    OP_CALC3,
    OP_ERASE_ADV,
    OP_TO_FRAG,
    OP_TO_IDLE,
    OP_FRAG_SHIFT,
    OP_FRAG_DONE,
    OP_FRAG_K,
    OP_PAGE_INC,
    OP_DATA_INC
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_NOT_S,
    C_HCNT_NZ,
    C_HCNT_NOT2,
    C_FRAG_NZ,
    C_MORE_ERASE,
    C_NO_PAGE,
    C_NO_COMMIT
  } cond_t;

  typedef enum logic [1:0] {
    CFG_START_SECTOR = 2'd0,
    CFG_SECTOR_LOG2  = 2'd1,
    CFG_PAGE_LOG2    = 2'd2
  } cfg_reg_t;

  // microprogram entry points
  localparam upc_t U_DISP   = 5'd0;
  localparam upc_t U_IDLE   = 5'd1;
  localparam upc_t U_LEN    = 5'd5;
  localparam upc_t U_ERASE  = 5'd13;
  localparam upc_t U_ANN    = 5'd14;
  localparam upc_t U_OK     = 5'd19;
  localparam upc_t U_FRAG   = 5'd20;
  localparam upc_t U_COMMIT = 5'd25;
  localparam upc_t U_DATA   = 5'd29;

  localparam logic [7:0] CH_START = 8'h73;  // 's'
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_K     = 8'h6b;
  localparam logic [7:0] CH_O     = 8'h6f;

  typedef struct packed {
    emit_t      emit;
    logic [7:0] ch;      // reply char, or digit select for EM_HEX
    last_sel_t  lsel;
    op_t        op;
    cond_t      cond;
    upc_t       target;
  } ctrl_t;

  typedef struct packed {
    phase_t phase;
    logic   b_is_s;
    logic   hcnt_nz;
    logic   hcnt_is2;
    logic   frag_nz;
    logic   more_erase;
    logic   no_page;
    logic   no_commit;
    logic   out_free;
  } stat_t;

  function automatic ctrl_t mk(emit_t e, logic [7:0] c, last_sel_t l, op_t o,
                               cond_t cd, upc_t t);
    ctrl_t w;
    w.emit   = e;
    w.ch     = c;
    w.lsel   = l;
    w.op     = o;
    w.cond   = cd;
    w.target = t;
    return w;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) r = 8'h30 + {4'd0, d};
    else           r = 8'h57 + {4'd0, d};
    return r;
  endfunction

endpackage

/* rtl/core/bdr_ucode_rom.sv */
module bdr_ucode_rom (
  input  bdr_pkg::upc_t  upc,
  output bdr_pkg::ctrl_t ctrl
);

  always_comb begin
    unique case (upc)
      // dispatch on phase once a byte is taken
      5'd0:  ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_DISPATCH, bdr_pkg::U_DISP);
      // idle: drop anything but the start byte
      5'd1:  ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_NOT_S, bdr_pkg::U_DISP);
      5'd2:  ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_A, bdr_pkg::L_NO,
                                bdr_pkg::OP_START, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd3:  ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_C, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd4:  ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_K, bdr_pkg::L_YES,
                                bdr_pkg::OP_NONE, bdr_pkg::C_ALWAYS, bdr_pkg::U_DISP);
      // total length
      5'd5:  ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO,
                                bdr_pkg::OP_LEN_SHIFT, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd6:  ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_HCNT_NZ, bdr_pkg::U_DISP);
      5'd7:  ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_A, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd8:  ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_C, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd9:  ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_K, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd10: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_CALC1,
                                bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd11: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_CALC2,
                                bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd12: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_CALC3,
                                bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd13: ctrl = bdr_pkg::mk(bdr_pkg::EM_ERASE, 8'd0, bdr_pkg::L_NO,
                                bdr_pkg::OP_ERASE_ADV, bdr_pkg::C_MORE_ERASE,
                                bdr_pkg::U_ERASE);
      // announce next page or finish
      5'd14: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_NO_PAGE, bdr_pkg::U_OK);
      5'd15: ctrl = bdr_pkg::mk(bdr_pkg::EM_HEX, 8'd3, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd16: ctrl = bdr_pkg::mk(bdr_pkg::EM_HEX, 8'd2, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd17: ctrl = bdr_pkg::mk(bdr_pkg::EM_HEX, 8'd1, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd18: ctrl = bdr_pkg::mk(bdr_pkg::EM_HEX, 8'd0, bdr_pkg::L_YES,
                                bdr_pkg::OP_TO_FRAG, bdr_pkg::C_ALWAYS, bdr_pkg::U_DISP);
      5'd19: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_O, bdr_pkg::L_YES,
                                bdr_pkg::OP_TO_IDLE, bdr_pkg::C_ALWAYS, bdr_pkg::U_DISP);
      // fragment length
      5'd20: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO,
                                bdr_pkg::OP_FRAG_SHIFT, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd21: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_HCNT_NOT2, bdr_pkg::U_DISP);
      5'd22: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_A, bdr_pkg::L_NO,
                                bdr_pkg::OP_FRAG_DONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd23: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_C, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd24: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_K, bdr_pkg::L_FRAG_NZ,
                                bdr_pkg::OP_FRAG_K, bdr_pkg::C_FRAG_NZ, bdr_pkg::U_DISP);
      // page commit
      5'd25: ctrl = bdr_pkg::mk(bdr_pkg::EM_COMMIT, 8'd0, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd26: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_A, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd27: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_C, bdr_pkg::L_NO,
                                bdr_pkg::OP_NONE, bdr_pkg::C_NEXT, bdr_pkg::U_DISP);
      5'd28: ctrl = bdr_pkg::mk(bdr_pkg::EM_CHAR, bdr_pkg::CH_K, bdr_pkg::L_NO,
                                bdr_pkg::OP_PAGE_INC, bdr_pkg::C_ALWAYS, bdr_pkg::U_ANN);
      // page data
      5'd29: ctrl = bdr_pkg::mk(bdr_pkg::EM_DATA, 8'd0, bdr_pkg::L_NO_COMMIT,
                                bdr_pkg::OP_DATA_INC, bdr_pkg::C_NO_COMMIT, bdr_pkg::U_DISP);
      5'd30: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                bdr_pkg::C_ALWAYS, bdr_pkg::U_COMMIT);
      default: ctrl = bdr_pkg::mk(bdr_pkg::EM_NONE, 8'd0, bdr_pkg::L_NO, bdr_pkg::OP_NONE,
                                  bdr_pkg::C_ALWAYS, bdr_pkg::U_DISP);
    endcase
  end

endmodule

/* rtl/core/bdr_seq.sv */
module bdr_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  bdr_pkg::ctrl_t ctrl,
  input  bdr_pkg::stat_t stat,
  output bdr_pkg::upc_t  upc,
  output logic           fire,
  output logic           in_ready
);

  bdr_pkg::upc_t upc_next;
  bdr_pkg::upc_t dispatch_target;
  logic          take;

  assign in_ready = (ctrl.cond == bdr_pkg::C_DISPATCH);

  // emit steps hold until the output register frees up
  always_comb begin
    if (in_ready) fire = in_valid;
    else          fire = (ctrl.emit == bdr_pkg::EM_NONE) || stat.out_free;
  end

  always_comb begin
    unique case (stat.phase)
      bdr_pkg::PH_IDLE: dispatch_target = bdr_pkg::U_IDLE;
      bdr_pkg::PH_LEN:  dispatch_target = bdr_pkg::U_LEN;
      bdr_pkg::PH_FRAG: dispatch_target = bdr_pkg::U_FRAG;
      bdr_pkg::PH_DATA: dispatch_target = bdr_pkg::U_DATA;
      default:          dispatch_target = bdr_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      bdr_pkg::C_NEXT:       take = 1'b0;
      bdr_pkg::C_ALWAYS:     take = 1'b1;
      bdr_pkg::C_DISPATCH:   take = 1'b1;
      bdr_pkg::C_NOT_S:      take = !stat.b_is_s;
      bdr_pkg::C_HCNT_NZ:    take = stat.hcnt_nz;
      bdr_pkg::C_HCNT_NOT2:  take = !stat.hcnt_is2;
      bdr_pkg::C_FRAG_NZ:    take = stat.frag_nz;
      bdr_pkg::C_MORE_ERASE: take = stat.more_erase;
      bdr_pkg::C_NO_PAGE:    take = stat.no_page;
      bdr_pkg::C_NO_COMMIT:  take = stat.no_commit;
      default:               take = 1'b1;
    endcase
    if (!take)        upc_next = upc + bdr_pkg::upc_t'(1);
    else if (in_ready) upc_next = dispatch_target;
    else              upc_next = ctrl.target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= bdr_pkg::U_DISP;
    end else if (fire) begin
      upc <= upc_next;
    end
  end

endmodule

/* rtl/core/bdr_datapath.sv */
module bdr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bdr_pkg::ctrl_t                ctrl,
  input  logic                          fire,
  input  logic                          in_take,
  input  logic [7:0]                    in_byte,
  input  logic                          cfg_take,
  input  logic [1:0]                    cfg_index,
  input  logic [12:0]                   cfg_data,
  input  logic                          out_ready,
  output bdr_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic [bdr_pkg::TDATA_W-1:0]   out_data,
  output logic [1:0]                    out_user,
  output logic                          out_last
);

  // configuration
  logic [12:0] start_sector;
  logic [4:0]  sector_log2;
  logic [3:0]  page_log2;

  // download state
  bdr_pkg::phase_t phase;
  logic [1:0]      hcnt;
  logic [31:0]     total_length;
  logic [31:0]     pages_needed;
  logic [31:0]     page_index;
  logic [15:0]     frag_len;
  logic [15:0]     data_index;
  logic [7:0]      rx;
  logic [32:0]     sum;
  bdr_pkg::sec_t   sec_total;
  bdr_pkg::sec_t   sec_idx;
  logic            clamp;
  bdr_pkg::addr_t  erase_addr;

  // result register
  logic [1:0]  r_action;
  logic [7:0]  r_char;
  logic [23:0] r_addr;
  logic [7:0]  r_data;
  logic [15:0] r_off;
  logic [15:0] r_len;
  logic        r_clamp;
  logic        r_last;

  bdr_pkg::addr_t           start_addr;
  bdr_pkg::addr_t           commit_addr;
  logic [32:0]              sec_shift;
  logic [32:0]              page_shift;
  logic                     sec_over;
  logic [bdr_pkg::SEC_W:0]  idx_inc;
  logic [15:0]              data_inc;
  logic [15:0]              page_lo;
  logic [3:0]               hex_digit;
  logic                     emit_go;
  logic                     last_bit;

  assign start_addr  = (bdr_pkg::addr_t'(start_sector) - bdr_pkg::addr_t'(1)) << sector_log2;
  assign commit_addr = start_addr + (bdr_pkg::addr_t'(page_index) << page_log2);
  assign sec_shift   = sum >> sector_log2;
  assign page_shift  = sum >> page_log2;
  assign sec_over    = sec_shift > 33'(bdr_pkg::MAX_SECTORS);
  assign idx_inc     = {1'b0, sec_idx} + {{bdr_pkg::SEC_W{1'b0}}, 1'b1};
  assign data_inc    = data_index + 16'd1;
  assign page_lo     = page_index[15:0];
  assign hex_digit   = page_lo[{ctrl.ch[1:0], 2'b00} +: 4];

  always_comb begin
    stat.phase      = phase;
    stat.b_is_s     = (rx == bdr_pkg::CH_START);
    stat.hcnt_nz    = (hcnt != 2'd0);
    stat.hcnt_is2   = (hcnt == 2'd2);
    stat.frag_nz    = (frag_len != 16'd0);
    stat.more_erase = idx_inc < {1'b0, sec_total};
    stat.no_page    = !(page_index < pages_needed);
    stat.no_commit  = (data_inc != frag_len);
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    unique case (ctrl.lsel)
      bdr_pkg::L_NO:        last_bit = 1'b0;
      bdr_pkg::L_YES:       last_bit = 1'b1;
      bdr_pkg::L_FRAG_NZ:   last_bit = stat.frag_nz;
      bdr_pkg::L_NO_COMMIT: last_bit = stat.no_commit;
      default:              last_bit = 1'b0;
    endcase
  end

  assign emit_go = fire && (ctrl.emit != bdr_pkg::EM_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_sector <= 13'd1;
      sector_log2  <= 5'd12;
      page_log2    <= 4'd8;
    end else if (cfg_take) begin
      case (cfg_index)
        bdr_pkg::CFG_START_SECTOR: start_sector <= cfg_data;
        bdr_pkg::CFG_SECTOR_LOG2:  sector_log2  <= cfg_data[4:0];
        bdr_pkg::CFG_PAGE_LOG2:    page_log2    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) rx <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bdr_pkg::PH_IDLE;
      hcnt         <= 2'd0;
      total_length <= 32'd0;
      pages_needed <= 32'd0;
      page_index   <= 32'd0;
      frag_len     <= 16'd0;
      data_index   <= 16'd0;
      sum          <= 33'd0;
      sec_total    <= '0;
      sec_idx      <= '0;
      clamp        <= 1'b0;
      erase_addr   <= '0;
    end else if (fire) begin
      case (ctrl.op)
        bdr_pkg::OP_START: begin
          phase        <= bdr_pkg::PH_LEN;
          hcnt         <= 2'd0;
          total_length <= 32'd0;
        end
        bdr_pkg::OP_LEN_SHIFT: begin
          total_length <= {total_length[23:0], rx};
          hcnt         <= hcnt + 2'd1;
        end
        bdr_pkg::OP_CALC1: begin
          sum        <= {1'b0, total_length} + ((33'd1 << sector_log2) - 33'd1);
          erase_addr <= start_addr;
          sec_idx    <= '0;
        end
        bdr_pkg::OP_CALC2: begin
          if (sec_over) begin
            sec_total <= bdr_pkg::sec_t'(bdr_pkg::MAX_SECTORS);
            clamp     <= 1'b1;
          end else begin
            sec_total <= (sec_shift == 33'd0) ? bdr_pkg::sec_t'(1) :
                         sec_shift[bdr_pkg::SEC_W-1:0];
            clamp     <= 1'b0;
          end
          sum <= {1'b0, total_length} + ((33'd1 << page_log2) - 33'd1);
        end
        bdr_pkg::OP_CALC3: begin
          pages_needed <= page_shift[31:0];
          page_index   <= 32'd0;
        end
        bdr_pkg::OP_ERASE_ADV: begin
          erase_addr <= erase_addr + (bdr_pkg::addr_t'(1) << sector_log2);
          sec_idx    <= idx_inc[bdr_pkg::SEC_W-1:0];
        end
        bdr_pkg::OP_TO_FRAG: begin
          phase <= bdr_pkg::PH_FRAG;
          hcnt  <= 2'd0;
        end
        bdr_pkg::OP_TO_IDLE: begin
          phase <= bdr_pkg::PH_IDLE;
          hcnt  <= 2'd0;
        end
        bdr_pkg::OP_FRAG_SHIFT: begin
          frag_len <= {frag_len[7:0], rx};
          hcnt     <= hcnt + 2'd1;
        end
        bdr_pkg::OP_FRAG_DONE: begin
          hcnt       <= 2'd0;
          data_index <= 16'd0;
        end
        bdr_pkg::OP_FRAG_K: begin
          if (frag_len != 16'd0) phase <= bdr_pkg::PH_DATA;
        end
        bdr_pkg::OP_PAGE_INC: page_index <= page_index + 32'd1;
        bdr_pkg::OP_DATA_INC: data_index <= data_inc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      r_char  <= 8'd0;
      r_addr  <= 24'd0;
      r_data  <= 8'd0;
      r_off   <= 16'd0;
      r_len   <= 16'd0;
      r_clamp <= 1'b0;
      r_last  <= last_bit;
      case (ctrl.emit)
        bdr_pkg::EM_CHAR: begin
          r_action <= bdr_pkg::ACT_REPLY;
          r_char   <= ctrl.ch;
        end
        bdr_pkg::EM_HEX: begin
          r_action <= bdr_pkg::ACT_REPLY;
          r_char   <= bdr_pkg::hex_char(hex_digit);
        end
        bdr_pkg::EM_ERASE: begin
          r_action <= bdr_pkg::ACT_ERASE;
          r_addr   <= 24'(erase_addr);
          r_clamp  <= clamp;
        end
        bdr_pkg::EM_DATA: begin
          r_action <= bdr_pkg::ACT_DATA;
          r_data   <= rx;
          r_off    <= data_index;
        end
        default: begin
          r_action <= bdr_pkg::ACT_COMMIT;
          r_addr   <= 24'(commit_addr);
          r_len    <= frag_len;
        end
      endcase
    end
  end

  assign out_data = {7'd0, r_clamp, r_len, r_off, r_data, r_addr, r_char};
  assign out_user = r_action;
  assign out_last = r_last;

  a_erase_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit == bdr_pkg::EM_ERASE) |->
      (sec_idx < sec_total) && (sec_total != '0))
    else $error("erase step outside the sector run");

  a_data_needs_len: assert property (@(posedge clk) disable iff (rst)
    (phase == bdr_pkg::PH_DATA) |-> (frag_len != 16'd0))
    else $error("data phase with empty fragment");

  a_frag_hcnt: assert property (@(posedge clk) disable iff (rst)
    (phase == bdr_pkg::PH_FRAG) |-> (hcnt != 2'd3))
    else $error("fragment header count overran");

  a_clamp_only_erase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_user != bdr_pkg::ACT_ERASE)) |-> !out_data[72])
    else $error("clamp flag on a non-erase result");

endmodule

/* rtl/core/bitstream_download_receiver.sv */
// Bitstream download receiver.
// s_* carries received link bytes; m_* carries replies and flash actions.
// cfg_* writes start_sector (0), sector_size_log2 (1) and page_size_log2 (2);
// write it only between downloads or between bytes with the output drained.
// A microprogram steps through each byte: s_tready is high only on the
// dispatch step, then the byte runs through its microsteps. An idle byte is
// checked for 's', answered with "ack"; a length byte is shifted in; a data
// byte emits a data request (on the last byte of a fragment also the commit
// and ack plus the announcement). The second fragment length byte emits an
// ack, followed by the commit when the fragment is empty. The fourth length
// byte emits an ack, one erase per sector and a page announcement or 'o'.
// Each result is one m_* request; the microsequencer emits at most one per
// cycle through a single output register and holds an emit step while a
// result waits with m_tready low, so a stalled receiver stalls input.
// m_tlast marks the final result caused by an input byte.
// Reset returns to idle (waiting for 's') and loads the register defaults
// 1, 12 and 8; no clearing pass is needed.
module bitstream_download_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] reply_char, [31:8] flash_address,
                                 // [39:32] data_byte, [55:40] byte_offset,
                                 // [71:56] write_length, [72] erase_clamped
  output logic [1:0]  m_tuser,   // [1:0] action
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  bdr_pkg::upc_t  upc;
  bdr_pkg::ctrl_t ctrl;
  bdr_pkg::stat_t stat;
  logic           fire;

  assign cfg_ready = 1'b1;

  bdr_ucode_rom u_rom (
    .upc  (upc),
    .ctrl (ctrl)
  );

  bdr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .ctrl     (ctrl),
    .stat     (stat),
    .upc      (upc),
    .fire     (fire),
    .in_ready (s_tready)
  );

  bdr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .fire      (fire),
    .in_take   (s_tvalid && s_tready),
    .in_byte   (s_tdata),
    .cfg_take  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

/* dv/bitstream_download_receiver_test.sv */
`timescale 1ns / 100ps

module bitstream_download_receiver_test;

  typedef struct packed {
    logic [6:0]  pad;
    logic        erase_clamped;
    logic [15:0] write_length;
    logic [15:0] byte_offset;
    logic [7:0]  data_byte;
    logic [23:0] flash_address;
    logic [7:0]  reply_char;
  } flash_fields_t;

  typedef struct packed {
    bdr_pkg::action_t action;
    logic             last;
    flash_fields_t    f;
  } flash_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [12:0] cfg_data = 13'd0;

  bitstream_download_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // register copies
  logic [12:0] start_sector = 13'd1;
  logic [4:0]  sector_log2 = 5'd12;
  logic [3:0]  page_log2 = 4'd8;

  // download state
  bdr_pkg::phase_t dl_phase = bdr_pkg::PH_IDLE;
  logic [1:0]  hdr_cnt = 2'd0;
  logic [31:0] total_len = 32'd0;
  logic [31:0] pages_needed = 32'd0;
  logic [31:0] page_idx = 32'd0;
  logic [15:0] frag_len = 16'd0;
  logic [15:0] data_idx = 16'd0;

  logic [7:0]  link_q[$];
  flash_req_t  expected_q[$];
  int          fail_count = 0;
  int          stim_count = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_cycles = 0;
  int          burst_left[2] = '{0, 0};

  // register sets, most beyond the usual ranges
  logic [12:0] ext_start[5] = '{13'd0, 13'd8191, 13'd4096, 13'd100, 13'd1};
  logic [4:0]  ext_sec[5]   = '{5'd31, 5'd0, 5'd20, 5'd8, 5'd8};
  logic [3:0]  ext_page[5]  = '{4'd15, 4'd0, 4'd12, 4'd15, 4'd4};

  function automatic int pick_gap(int side);
    int r;
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] base_addr();
    logic [63:0] s;
    s = ({51'd0, start_sector} - 64'd1) & 64'hFF_FFFF;
    return 24'(s << sector_log2);
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] d);
    if (d > 4'd9) return "a" + 8'(d) - 8'd10;
    return "0" + 8'(d);
  endfunction

  function automatic void push_req(bdr_pkg::action_t act, logic [7:0] ch,
                                   logic [23:0] addr, logic [7:0] db,
                                   logic [15:0] off, logic [15:0] len, logic cl);
    flash_req_t r;
    r.action          = act;
    r.last            = 1'b0;
    r.f.pad           = 7'd0;
    r.f.erase_clamped = cl;
    r.f.write_length  = len;
    r.f.byte_offset   = off;
    r.f.data_byte     = db;
    r.f.flash_address = addr;
    r.f.reply_char    = ch;
    expected_q.push_back(r);
  endfunction

  function automatic void push_char(logic [7:0] ch);
    push_req(bdr_pkg::ACT_REPLY, ch, 24'd0, 8'd0, 16'd0, 16'd0, 1'b0);
  endfunction

  function automatic void push_ack();
    push_char(bdr_pkg::CH_A);
    push_char(bdr_pkg::CH_C);
    push_char(bdr_pkg::CH_K);
  endfunction

  function automatic void announce_page();
    logic [15:0] p;
    p = page_idx[15:0];
    if (page_idx < pages_needed) begin
      push_char(nibble_char(p[15:12]));
      push_char(nibble_char(p[11:8]));
      push_char(nibble_char(p[7:4]));
      push_char(nibble_char(p[3:0]));
      dl_phase = bdr_pkg::PH_FRAG;
    end else begin
      push_char(bdr_pkg::CH_O);
      dl_phase = bdr_pkg::PH_IDLE;
    end
    hdr_cnt = 2'd0;
  endfunction

  function automatic void commit_page();
    logic [23:0] addr;
    addr = base_addr() + 24'({32'd0, page_idx} << page_log2);
    push_req(bdr_pkg::ACT_COMMIT, 8'd0, addr, 8'd0, 16'd0, frag_len, 1'b0);
    push_ack();
    page_idx++;
    announce_page();
  endfunction

  function automatic void erase_and_plan();
    logic [63:0] span;
    logic [63:0] sectors;
    logic        cl;
    span    = {32'd0, total_len};
    sectors = (span + (64'd1 << sector_log2) - 64'd1) >> sector_log2;
    cl      = 1'b0;
    if (sectors == 64'd0) sectors = 64'd1;
    if (sectors > 64'(bdr_pkg::MAX_SECTORS)) begin
      sectors = 64'(bdr_pkg::MAX_SECTORS);
      cl = 1'b1;
    end
    for (longint k = 0; k < longint'(sectors); k++)
      push_req(bdr_pkg::ACT_ERASE, 8'd0, base_addr() + 24'(64'(k) << sector_log2),
               8'd0, 16'd0, 16'd0, cl);
    pages_needed = 32'((span + (64'd1 << page_log2) - 64'd1) >> page_log2);
    page_idx = 32'd0;
    announce_page();
  endfunction

  function automatic void predict_link_byte(logic [7:0] b);
    int         n0;
    flash_req_t r;
    n0 = expected_q.size();
    case (dl_phase)
      bdr_pkg::PH_LEN: begin
        total_len = {total_len[23:0], b};
        hdr_cnt = hdr_cnt + 2'd1;
        if (hdr_cnt == 2'd0) begin
          push_ack();
          erase_and_plan();
        end
      end
      bdr_pkg::PH_FRAG: begin
        frag_len = {frag_len[7:0], b};
        hdr_cnt = hdr_cnt + 2'd1;
        if (hdr_cnt >= 2'd2) begin
          hdr_cnt = 2'd0;
          push_ack();
          data_idx = 16'd0;
          if (frag_len == 16'd0) commit_page();
          else dl_phase = bdr_pkg::PH_DATA;
        end
      end
      bdr_pkg::PH_DATA: begin
        push_req(bdr_pkg::ACT_DATA, 8'd0, 24'd0, b, data_idx, 16'd0, 1'b0);
        data_idx = data_idx + 16'd1;
        if (data_idx == frag_len) commit_page();
      end
      default: begin
        dl_phase = bdr_pkg::PH_IDLE;
        if (b == bdr_pkg::CH_START) begin
          push_ack();
          dl_phase = bdr_pkg::PH_LEN;
          hdr_cnt = 2'd0;
          total_len = 32'd0;
        end
      end
    endcase
    // mark the final request caused by this byte
    if (expected_q.size() > n0) begin
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endfunction

  task automatic check_result();
    flash_req_t    want;
    flash_fields_t got;
    got = m_tdata;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected request: action %0d last %b tdata %h",
                 $time, m_tuser, m_tlast, m_tdata);
    end else begin
      want = expected_q.pop_front();
      if (m_tuser !== want.action || m_tlast !== want.last ||
          got.reply_char !== want.f.reply_char ||
          got.flash_address !== want.f.flash_address ||
          got.data_byte !== want.f.data_byte ||
          got.byte_offset !== want.f.byte_offset ||
          got.write_length !== want.f.write_length ||
          got.erase_clamped !== want.f.erase_clamped || got.pad !== 7'd0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch: expected action %0d last %b tdata %h,",
                   $time, want.action, want.last, want.f,
                   " got action %0d last %b tdata %h", m_tuser, m_tlast, m_tdata);
      end
    end
  endtask

  // link byte driver
  always @(posedge clk) begin
    logic fire;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        predict_link_byte(s_tdata);
        tx_gap = pick_gap(0);
      end
      if (!s_tvalid || fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (link_q.size() > 0) begin
          s_tdata  <= link_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
        rx_gap = pick_gap(1);
      end
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic write_reg(bdr_pkg::cfg_reg_t idx, logic [12:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bdr_pkg::CFG_START_SECTOR: start_sector = v;
      bdr_pkg::CFG_SECTOR_LOG2:  sector_log2 = v[4:0];
      bdr_pkg::CFG_PAGE_LOG2:    page_log2 = v[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [12:0] ss, logic [4:0] sl, logic [3:0] pl);
    write_reg(bdr_pkg::CFG_START_SECTOR, ss);
    write_reg(bdr_pkg::CFG_SECTOR_LOG2, {8'd0, sl});
    write_reg(bdr_pkg::CFG_PAGE_LOG2, {9'd0, pl});
  endtask

  function automatic void queue_byte(logic [7:0] b);
    link_q.push_back(b);
    stim_count++;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == bdr_pkg::CH_START) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic int pick_frag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  // one complete download sized to the current page size
  function automatic void queue_download(int lo, int hi);
    int          npages;
    int          flen;
    logic [31:0] span;
    npages = $urandom_range(lo, hi);
    repeat ($urandom_range(0, 3)) link_q.push_back(noise_byte());
    if (npages == 0) span = 32'd0;
    else span = (32'(npages - 1) << page_log2) + 32'($urandom_range(1, 1 << page_log2));
    queue_byte(bdr_pkg::CH_START);
    queue_byte(span[31:24]);
    queue_byte(span[23:16]);
    queue_byte(span[15:8]);
    queue_byte(span[7:0]);
    repeat (npages) begin
      flen = pick_frag();
      queue_byte(8'(flen >> 8));
      queue_byte(8'(flen));
      repeat (flen) queue_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic wait_drained();
    while (link_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
    // let a byte that made no request finish its microsteps
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: ignored bytes around 's', empty download, empty fragment, two pages
    link_q.push_back(8'h00);
    link_q.push_back(8'hff);
    link_q.push_back(8'h72);
    link_q.push_back(8'h74);
    queue_byte(bdr_pkg::CH_START);
    repeat (4) queue_byte(8'h00);
    queue_byte(bdr_pkg::CH_START);
    queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h05);
    queue_byte(8'h00); queue_byte(8'h00);
    queue_byte(bdr_pkg::CH_START);
    queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'h2c);
    queue_byte(8'h00); queue_byte(8'h02); queue_byte(8'haa); queue_byte(8'h55);
    queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'h80);
    wait_drained();

    for (int i = 0; i < 5; i++) begin
      write_all(ext_start[i], ext_sec[i], ext_page[i]);
      // stall the receiver through a clamped erase run so the input backs up
      if (i == 3) hold_cycles = 400;
      queue_download(0, 4);
      queue_download(1, 4);
      wait_drained();
    end

    while (stim_count < 380) begin
      if ($urandom_range(0, 2) != 0)
        write_reg(bdr_pkg::CFG_START_SECTOR, 13'($urandom_range(0, 8191)));
      if ($urandom_range(0, 2) != 0)
        write_reg(bdr_pkg::CFG_SECTOR_LOG2, ($urandom_range(0, 3) == 0) ?
                  13'($urandom_range(0, 31)) : 13'($urandom_range(8, 20)));
      if ($urandom_range(0, 2) != 0)
        write_reg(bdr_pkg::CFG_PAGE_LOG2, ($urandom_range(0, 3) == 0) ?
                  13'($urandom_range(0, 15)) : 13'($urandom_range(4, 12)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) queue_download(12, 20);
        else queue_download(0, 5);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("bitstream_download_receiver_test: clean");
    end else begin
      $display("bitstream_download_receiver_test: errors");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("bitstream_download_receiver_test: errors");
    $finish;
  end

endmodule
